// ===== src/rme_pkg.sv =====
// Shared types and codes for the register machine execute block.
// Depends on nothing; the controller, datapath and top level import it.
package rme_pkg;

  // Instruction codes carried on the command field.
  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_MOD   = 3'd4,
    OP_MOVE  = 3'd5,
    OP_SHOW  = 3'd6
  } rme_op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DIVZ   = 2'd1,
    ST_MOD    = 2'd2,
    ST_HALTED = 2'd3
  } rme_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // capture the input beat and start the register reads
    logic fetch;     // latch both operands
    logic exec;      // decide, write simple results, arm the iterative unit
    logic step;      // one shift-add or shift-subtract step
    logic fix;       // sign-correct and write back the iterative result
    logic out_load;  // move the finished result into the output register
  } rme_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_iter;  // the item in execution needs the multiply/divide unit
    logic iter_last;  // the current step is the final one
  } rme_stat_t;

endpackage

// ===== src/rme_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// Depends on nothing.
module rme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== src/rme_ctrl.sv =====
// Controller state machine of the register machine execute block.
// Depends on rme_pkg for the command and status structs.
module rme_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  rme_pkg::rme_stat_t  stat,
  output rme_pkg::rme_cmd_t   cmd
);

  import rme_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_ITER,
    S_FIX,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.fetch    = (state_r == S_FETCH);
    cmd.exec     = (state_r == S_EXEC);
    cmd.step     = (state_r == S_ITER);
    cmd.fix      = (state_r == S_FIX);
    cmd.out_load = (state_r == S_DONE) && out_free;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = stat.need_iter ? S_ITER : S_DONE;
      end
      S_ITER: begin
        if (stat.iter_last) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/rme_dp.sv =====
// Datapath of the register machine execute block: register file, operand
// selection, add/sub/move, iterative multiply/divide unit, result registers.
// Depends on rme_pkg and rme_ram.
module rme_dp #(
  parameter int NUM_REGS   = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rme_pkg::rme_cmd_t         cmd,
  output rme_pkg::rme_stat_t        stat,
  input  logic [2:0]                in_command,
  input  logic                      in_print_req,
  input  logic [2:0]                in_dest_reg,
  input  logic                      in_a_is_imm,
  input  logic [2:0]                in_a_reg,
  input  logic signed [31:0]        in_a_imm,
  input  logic                      in_b_is_imm,
  input  logic [2:0]                in_b_reg,
  input  logic signed [31:0]        in_b_imm,
  output logic [1:0]                out_status,
  output logic                      out_print_valid,
  output logic signed [31:0]        out_print_value
);

  import rme_pkg::*;

  localparam int IDX_W = $clog2(NUM_REGS);
  localparam int DW    = DATA_WIDTH;
  localparam int CW    = $clog2(DATA_WIDTH);

  // Register index reduced modulo NUM_REGS by repeated subtraction.
  function automatic logic [IDX_W-1:0] reg_idx(input logic [2:0] idx);
    logic [5:0] v;
    v = {3'b000, idx};
    for (int k = 0; k < 4; k++) begin
      if (v >= 6'(NUM_REGS)) begin
        v = v - 6'(NUM_REGS);
      end
    end
    return v[IDX_W-1:0];
  endfunction

  // Immediate sign-extended from 32 bits, then wrapped to the data width.
  function automatic logic [DW-1:0] imm_ext(input logic [31:0] v);
    logic [63:0] e;
    e = {{32{v[31]}}, v};
    return e[DW-1:0];
  endfunction

  // Captured instruction.
  rme_op_t          op_r;
  logic             preq_r;
  logic [IDX_W-1:0] dst_r;
  logic             a_is_imm_r, b_is_imm_r;
  logic [31:0]      a_imm_r, b_imm_r;
  logic             a_vld_r, b_vld_r;

  // Operands and machine state.
  logic [DW-1:0]    a_r, b_r;
  logic             halted_r;
  logic [NUM_REGS-1:0] vld_r;

  // Iterative unit.
  logic [DW-1:0]    acc_r, x_r, y_r;
  logic [CW-1:0]    cnt_r;
  logic             neg_r, is_div_r;

  // Pending and output result.
  rme_status_t      res_status_r;
  logic             res_pvalid_r;
  logic [31:0]      res_pvalue_r;
  logic [1:0]       out_status_r;
  logic             out_pvalid_r;
  logic [31:0]      out_pvalue_r;

  logic [IDX_W-1:0] ra_idx, rb_idx;
  logic [DW-1:0]    ram_qa, ram_qb;
  logic             we;
  logic [DW-1:0]    wdata;
  logic             is_print;
  logic [DW-1:0]    a_mag, b_mag;
  logic [DW:0]      trial, diff;
  logic [DW-1:0]    iter_res;
  logic [63:0]      a_wide;

  assign ra_idx = reg_idx(in_a_reg);
  assign rb_idx = reg_idx(in_b_reg);

  rme_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_REGS)
  ) u_rf (
    .clk     (clk),
    .we      (we),
    .waddr   (dst_r),
    .wdata   (wdata),
    .re      (cmd.accept),
    .raddr_a (ra_idx),
    .raddr_b (rb_idx),
    .rdata_a (ram_qa),
    .rdata_b (ram_qb)
  );

  assign is_print = preq_r || (op_r == OP_SHOW);
  assign a_mag    = a_r[DW-1] ? (~a_r + 1'b1) : a_r;
  assign b_mag    = b_r[DW-1] ? (~b_r + 1'b1) : b_r;
  assign a_wide   = 64'(signed'(a_r));

  assign stat.need_iter = !halted_r && !is_print &&
                          ((op_r == OP_MUL) || ((op_r == OP_DIV) && (b_r != '0)));
  assign stat.iter_last = (cnt_r == CW'(DATA_WIDTH - 1));

  // Restoring division step: shift the next dividend bit into the remainder.
  assign trial    = {acc_r, x_r[DW-1]};
  assign diff     = trial - {1'b0, y_r};
  assign iter_res = is_div_r ? (neg_r ? (~x_r + 1'b1) : x_r) : acc_r;

  // Register file write port.
  always_comb begin
    we    = 1'b0;
    wdata = iter_res;
    if (cmd.exec && !halted_r && !is_print) begin
      case (op_r)
        OP_ADD: begin
          we    = 1'b1;
          wdata = a_r + b_r;
        end
        OP_SUB: begin
          we    = 1'b1;
          wdata = a_r - b_r;
        end
        OP_MOVE: begin
          we    = 1'b1;
          wdata = a_r;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end else if (cmd.fix) begin
      we = 1'b1;
    end
  end

  // Control-side state: halt flag and per-register written marks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r <= 1'b0;
      vld_r    <= '0;
    end else begin
      if (we) begin
        vld_r[dst_r] <= 1'b1;
      end
      if (cmd.exec && !halted_r && !is_print) begin
        if ((op_r == OP_MOD) || ((op_r == OP_DIV) && (b_r == '0))) begin
          halted_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= rme_op_t'(in_command);
      preq_r     <= in_print_req;
      dst_r      <= reg_idx(in_dest_reg);
      a_is_imm_r <= in_a_is_imm;
      b_is_imm_r <= in_b_is_imm;
      a_imm_r    <= in_a_imm;
      b_imm_r    <= in_b_imm;
      a_vld_r    <= vld_r[ra_idx];
      b_vld_r    <= vld_r[rb_idx];
    end

    if (cmd.fetch) begin
      a_r <= a_is_imm_r ? imm_ext(a_imm_r) : (a_vld_r ? ram_qa : '0);
      b_r <= b_is_imm_r ? imm_ext(b_imm_r) : (b_vld_r ? ram_qb : '0);
    end

    if (cmd.exec) begin
      res_status_r <= ST_OK;
      res_pvalid_r <= 1'b0;
      res_pvalue_r <= '0;
      cnt_r        <= '0;
      is_div_r     <= (op_r == OP_DIV);
      neg_r        <= a_r[DW-1] ^ b_r[DW-1];
      if (op_r == OP_DIV) begin
        acc_r <= '0;
        x_r   <= a_mag;
        y_r   <= b_mag;
      end else begin
        acc_r <= '0;
        x_r   <= a_r;
        y_r   <= b_r;
      end
      if (halted_r) begin
        res_status_r <= ST_HALTED;
      end else if (is_print) begin
        res_pvalid_r <= 1'b1;
        res_pvalue_r <= a_wide[31:0];
      end else if (op_r == OP_MOD) begin
        res_status_r <= ST_MOD;
      end else if ((op_r == OP_DIV) && (b_r == '0)) begin
        res_status_r <= ST_DIVZ;
      end
    end

    if (cmd.step) begin
      cnt_r <= cnt_r + 1'b1;
      if (is_div_r) begin
        if (!diff[DW]) begin
          acc_r <= diff[DW-1:0];
          x_r   <= {x_r[DW-2:0], 1'b1};
        end else begin
          acc_r <= trial[DW-1:0];
          x_r   <= {x_r[DW-2:0], 1'b0};
        end
      end else begin
        if (y_r[0]) begin
          acc_r <= acc_r + x_r;
        end
        x_r <= {x_r[DW-2:0], 1'b0};
        y_r <= {1'b0, y_r[DW-1:1]};
      end
    end

    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_pvalid_r <= res_pvalid_r;
      out_pvalue_r <= res_pvalue_r;
    end
  end

  assign out_status      = out_status_r;
  assign out_print_valid = out_pvalid_r;
  assign out_print_value = out_pvalue_r;

endmodule

// ===== src/register_machine_execute.sv =====
// Register machine execute block: top level joining controller and datapath.
// Add, sub, move, print, unused codes, faults and halted refusals pass from
// the accepted beat through fetch, execute and result hand-off; mul and div
// add the one-bit-per-cycle shift-add/shift-subtract steps and write-back.
// No new beat is taken until the result reaches the result register; the
// next beat can be accepted in the same cycle as that result is presented.
// Reset (rst_n low, synchronous) clears the halt flag, the controller and the
// written marks of the register file, so every register reads as zero.
module register_machine_execute #(
  parameter int NUM_REGS   = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel: one decoded instruction per beat.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic               in_print_req,
  input  logic [2:0]         in_dest_reg,
  input  logic               in_a_is_imm,
  input  logic [2:0]         in_a_reg,
  input  logic signed [31:0] in_a_imm,
  input  logic               in_b_is_imm,
  input  logic [2:0]         in_b_reg,
  input  logic signed [31:0] in_b_imm,
  // Result channel: exactly one beat per instruction.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_print_valid,
  output logic signed [31:0] out_print_value
);

  import rme_pkg::*;

  // The controller sequences each instruction through fetch, execute, the
  // optional iterative multiply/divide steps, write-back and result hand-off.
  // The datapath owns the register file, the halt flag and all payload.
  rme_cmd_t  cmd;
  rme_stat_t stat;

  rme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Register reads are launched on the accepting edge, so the operands are
  // ready to be latched in the fetch state that follows; the result register lets a finished result
  // wait on a stalled consumer while the next instruction is accepted.
  rme_dp #(
    .NUM_REGS   (NUM_REGS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (in_command),
    .in_print_req    (in_print_req),
    .in_dest_reg     (in_dest_reg),
    .in_a_is_imm     (in_a_is_imm),
    .in_a_reg        (in_a_reg),
    .in_a_imm        (in_a_imm),
    .in_b_is_imm     (in_b_is_imm),
    .in_b_reg        (in_b_reg),
    .in_b_imm        (in_b_imm),
    .out_status      (out_status),
    .out_print_valid (out_print_valid),
    .out_print_value (out_print_value)
  );

endmodule
